### rtl/stt_pkg.sv
// shared types and constants of the sparse triplet transpose core
package stt_pkg;

    localparam int ENTRY_CAPACITY_DEF = 64;
    localparam int MAX_DIMENSION_DEF  = 256;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] ROW_COUNT_RESET = 9'd256;
    localparam logic [CFG_DATA_W-1:0] COL_COUNT_RESET = 9'd256;

    typedef struct packed {
        logic [7:0]         in_row;
        logic [7:0]         in_col;
        logic signed [31:0] in_value;
        logic               has_entry;
        logic               last_item;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         out_row;
        logic [7:0]         out_col;
        logic signed [31:0] out_value;
        logic               out_valid;
        logic               out_last;
    } out_item_t;

endpackage

### rtl/sparse_triplet_transpose_core.sv
// fast transpose of a sparse matrix streamed as (row, column, value) triplets
// Items are loaded one at a time; each kept entry is stored and then its
// column count is read-modify-written in the count memory, with in_stall
// high during that update. The item marked last starts the transpose: a
// prefix sum over the count memory, then each stored entry is placed (entry
// read, start read, write), and each result is then read from the
// transposed memory, waiting while out_stall holds the output. Entries
// outside row_count/col_count, with a column at or beyond MAX_DIMENSION, or
// beyond ENTRY_CAPACITY are dropped; an empty matrix gives one result with
// out_valid clear and out_last set. After reset the count memory is cleared,
// during which no item is accepted; configuration writes are taken at any
// time.
module sparse_triplet_transpose_core #(
    parameter int ENTRY_CAPACITY = stt_pkg::ENTRY_CAPACITY_DEF,
    parameter int MAX_DIMENSION  = stt_pkg::MAX_DIMENSION_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  stt_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output stt_pkg::out_item_t                  out_data,
    input  logic                                cfg_we,
    input  logic [stt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [stt_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import stt_pkg::*;

    localparam int DW = $clog2(MAX_DIMENSION);
    localparam int PW = DW + 1;
    localparam int CW = $clog2(ENTRY_CAPACITY + 1);
    localparam int EW = (ENTRY_CAPACITY > 1) ? $clog2(ENTRY_CAPACITY) : 1;

    typedef struct packed {
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [31:0] value;
    } entry_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INC,
        S_PREFIX,
        S_SC_ENT,
        S_SC_START,
        S_SC_WR,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMPTY
    } state_t;

    function automatic logic [DW-1:0] col_addr(input logic [7:0] c);
        logic [DW+7:0] w;
        w = (DW+8)'(c);
        return w[DW-1:0];
    endfunction

    state_t          state_reg;
    logic [CFG_DATA_W-1:0] row_count_reg;
    logic [CFG_DATA_W-1:0] col_count_reg;
    logic [CW-1:0]   total_reg;
    logic [CW-1:0]   idx_reg;
    logic [CW-1:0]   acc_reg;
    logic [PW-1:0]   pre_idx_reg;
    logic [DW-1:0]   pre_addr_reg;
    logic            pre_vld_reg;
    logic [DW-1:0]   inc_col_reg;
    logic            last_pend_reg;
    logic            out_valid_reg;
    out_item_t       out_data_reg;

    // memories and their registered read data
    entry_t          entry_mem [ENTRY_CAPACITY];
    entry_t          trans_mem [ENTRY_CAPACITY];
    logic [CW-1:0]   cnt_mem   [MAX_DIMENSION];
    logic [CW-1:0]   start_mem [MAX_DIMENSION];
    entry_t          ent_rd_reg;
    entry_t          tr_rd_reg;
    logic [CW-1:0]   cnt_rd_reg;
    logic [CW-1:0]   start_rd_reg;

    logic            ent_we, ent_re, tr_we, tr_re;
    logic            cnt_we, cnt_re, st_we, st_re;
    logic [DW-1:0]   cnt_waddr, cnt_raddr, st_waddr, st_raddr;
    logic [CW-1:0]   cnt_wdata, st_wdata;

    logic            row_ok, col_ok, room, keep, out_free, pre_more, out_load;

    assign row_ok   = {1'b0, in_data.in_row} < row_count_reg;
    assign col_ok   = ({1'b0, in_data.in_col} < col_count_reg)
                   && ((DW+8)'(in_data.in_col) < (DW+8)'(MAX_DIMENSION));
    assign room     = total_reg < CW'(ENTRY_CAPACITY);
    assign keep     = in_data.has_entry && row_ok && col_ok && room;
    assign out_free = !out_valid_reg || !out_stall;
    assign pre_more = pre_idx_reg < PW'(MAX_DIMENSION);
    assign out_load = ((state_reg == S_EMIT_LD) || (state_reg == S_EMPTY)) && out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        ent_we    = 1'b0;
        ent_re    = 1'b0;
        tr_we     = 1'b0;
        tr_re     = 1'b0;
        cnt_we    = 1'b0;
        cnt_re    = 1'b0;
        st_we     = 1'b0;
        st_re     = 1'b0;
        cnt_waddr = '0;
        cnt_raddr = '0;
        st_waddr  = '0;
        st_raddr  = '0;
        cnt_wdata = '0;
        st_wdata  = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = pre_idx_reg[DW-1:0];
            end
            S_IDLE:
            begin
                ent_we    = in_valid && keep;
                cnt_re    = in_valid && keep;
                cnt_raddr = col_addr(in_data.in_col);
            end
            S_INC:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = inc_col_reg;
                cnt_wdata = cnt_rd_reg + CW'(1);
            end
            S_PREFIX:
            begin
                cnt_re    = pre_more;
                cnt_raddr = pre_idx_reg[DW-1:0];
                // start of each column is the running sum; its count clears
                cnt_we    = pre_vld_reg;
                cnt_waddr = pre_addr_reg;
                st_we     = pre_vld_reg;
                st_waddr  = pre_addr_reg;
                st_wdata  = acc_reg;
            end
            S_SC_ENT:
            begin
                ent_re = 1'b1;
            end
            S_SC_START:
            begin
                st_re    = 1'b1;
                st_raddr = col_addr(ent_rd_reg.col);
            end
            S_SC_WR:
            begin
                tr_we    = 1'b1;
                st_we    = 1'b1;
                st_waddr = col_addr(ent_rd_reg.col);
                st_wdata = start_rd_reg + CW'(1);
            end
            S_EMIT_RD:
            begin
                tr_re = 1'b1;
            end
            S_EMIT_LD, S_EMPTY:
            begin
                tr_re = 1'b0;
            end
            default:
            begin
                tr_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[total_reg[EW-1:0]] <= '{row: in_data.in_row, col: in_data.in_col,
                                              value: in_data.in_value};
        end
        if (ent_re)
        begin
            ent_rd_reg <= entry_mem[idx_reg[EW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tr_we)
        begin
            trans_mem[start_rd_reg[EW-1:0]] <= '{row: ent_rd_reg.col, col: ent_rd_reg.row,
                                                 value: ent_rd_reg.value};
        end
        if (tr_re)
        begin
            tr_rd_reg <= trans_mem[idx_reg[EW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rd_reg <= cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            start_mem[st_waddr] <= st_wdata;
        end
        if (st_re)
        begin
            start_rd_reg <= start_mem[st_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            row_count_reg <= ROW_COUNT_RESET;
            col_count_reg <= COL_COUNT_RESET;
            total_reg     <= '0;
            idx_reg       <= '0;
            acc_reg       <= '0;
            pre_idx_reg   <= '0;
            pre_addr_reg  <= '0;
            pre_vld_reg   <= 1'b0;
            inc_col_reg   <= '0;
            last_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ROW_COUNT: row_count_reg <= cfg_data;
                    REG_COL_COUNT: col_count_reg <= cfg_data;
                    default:       row_count_reg <= row_count_reg;
                endcase
            end

            // a new result is loaded only once the output register is free
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    pre_idx_reg <= pre_idx_reg + PW'(1);
                    if (pre_idx_reg == PW'(MAX_DIMENSION - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (keep)
                        begin
                            total_reg     <= total_reg + CW'(1);
                            inc_col_reg   <= col_addr(in_data.in_col);
                            last_pend_reg <= in_data.last_item;
                            state_reg     <= S_INC;
                        end
                        else if (in_data.last_item)
                        begin
                            pre_idx_reg <= '0;
                            pre_vld_reg <= 1'b0;
                            acc_reg     <= '0;
                            state_reg   <= (total_reg == '0) ? S_EMPTY : S_PREFIX;
                        end
                    end
                end
                S_INC:
                begin
                    pre_idx_reg <= '0;
                    pre_vld_reg <= 1'b0;
                    acc_reg     <= '0;
                    state_reg   <= last_pend_reg ? S_PREFIX : S_IDLE;
                end
                S_PREFIX:
                begin
                    pre_vld_reg <= pre_more;
                    if (pre_more)
                    begin
                        pre_idx_reg  <= pre_idx_reg + PW'(1);
                        pre_addr_reg <= pre_idx_reg[DW-1:0];
                    end
                    if (pre_vld_reg)
                    begin
                        acc_reg <= acc_reg + cnt_rd_reg;
                        if (pre_addr_reg == DW'(MAX_DIMENSION - 1))
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_SC_ENT;
                        end
                    end
                end
                S_SC_ENT:
                begin
                    state_reg <= S_SC_START;
                end
                S_SC_START:
                begin
                    state_reg <= S_SC_WR;
                end
                S_SC_WR:
                begin
                    if ((idx_reg + CW'(1)) == total_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SC_ENT;
                    end
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= '{out_row: tr_rd_reg.row, out_col: tr_rd_reg.col,
                                           out_value: tr_rd_reg.value, out_valid: 1'b1,
                                           out_last: (idx_reg + CW'(1)) == total_reg};
                        if ((idx_reg + CW'(1)) == total_reg)
                        begin
                            total_reg <= '0;
                            idx_reg   <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                S_EMPTY:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= '{out_row: 8'd0, out_col: 8'd0, out_value: 32'sd0,
                                           out_valid: 1'b0, out_last: 1'b1};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // entry count stays within the store
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(ENTRY_CAPACITY))
        else $error("entry total beyond capacity");

    // a placed entry always lands inside the list being built
    a_place_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SC_WR) |-> (start_rd_reg < total_reg))
        else $error("transposed position outside list");

    // only the final item of a list may carry no entry
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.out_valid) |-> out_data_reg.out_last)
        else $error("empty result not marked last");

    // a kept entry is always followed by its count update
    a_inc_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && keep) |=> (state_reg == S_INC))
        else $error("column count update skipped");

endmodule
